// ===== src/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// sae_pkg: shared types and constants for the swept box entry-time block
// holds the beat structs, side codes and default widths
// ----------------------------------------------------------------------------
package sae_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int MOVE_FRAC_BITS_DEF = 8;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int MOVE_W             = 20;
    localparam int SIDE_W             = 3;

    localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS_DEF-1:0] my_left;
        logic signed [COORD_BITS_DEF-1:0] my_top;
        logic signed [COORD_BITS_DEF-1:0] my_right;
        logic signed [COORD_BITS_DEF-1:0] my_bottom;
        logic signed [COORD_BITS_DEF-1:0] other_left;
        logic signed [COORD_BITS_DEF-1:0] other_top;
        logic signed [COORD_BITS_DEF-1:0] other_right;
        logic signed [COORD_BITS_DEF-1:0] other_bottom;
        logic signed [MOVE_W-1:0]         move_x;
        logic signed [MOVE_W-1:0]         move_y;
    } in_beat_t;

    typedef struct packed {
        logic                        hit;
        logic [TIME_FRAC_BITS_DEF:0] entry_time;
        logic [SIDE_W-1:0]           side_code;
    } out_beat_t;

endpackage

// ===== src/sae_div_cell.sv =====
// ----------------------------------------------------------------------------
// sae_div_cell: one restoring-division step of the quotient chain
// takes the partial remainder, emits one quotient bit, passes the rest on
// ----------------------------------------------------------------------------
module sae_div_cell #(
    parameter int REM_W  = 40,
    parameter int QUO_W  = 41,
    parameter int SIDE_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [REM_W-1:0]  rem_in,
    input  logic [REM_W-1:0]  den_in,
    input  logic [QUO_W-1:0]  num_in,
    input  logic [QUO_W-1:0]  quo_in,
    input  logic              hit_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [REM_W-1:0]  rem_out,
    output logic [REM_W-1:0]  den_out,
    output logic [QUO_W-1:0]  num_out,
    output logic [QUO_W-1:0]  quo_out,
    output logic              hit_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  den_reg;
    logic [QUO_W-1:0]  num_reg, quo_reg, quo_next;
    logic              hit_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [REM_W:0]    trial;

    // shift in next numerator bit and try a subtract
    always_comb
    begin
        trial = {rem_in, num_in[QUO_W-1]} - {1'b0, den_in};
        if (!trial[REM_W])
        begin
            rem_next = trial[REM_W-1:0];
            quo_next = {quo_in[QUO_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_in[REM_W-2:0], num_in[QUO_W-1]};
            quo_next = {quo_in[QUO_W-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            num_reg  <= {num_in[QUO_W-2:0], 1'b0};
            quo_reg  <= quo_next;
            hit_reg  <= hit_in;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign num_out  = num_reg;
    assign quo_out  = quo_reg;
    assign hit_out  = hit_reg;
    assign side_out = side_reg;

endmodule

// ===== src/sae_front.sv =====
// ----------------------------------------------------------------------------
// sae_front: gaps, exact time compares, hit decision and face select
// three register stages: gaps, cross product compares, then the decision
// ----------------------------------------------------------------------------
module sae_front #(
    parameter int COORD_BITS     = 16,
    parameter int MOVE_FRAC_BITS = 8,
    parameter int MOVE_W         = 20,
    parameter int SIDE_W         = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          vld_in,
    input  logic signed [COORD_BITS-1:0]  ml, mt, mr, mb, ol, ot, orr, ob,
    input  logic signed [MOVE_W-1:0]      mvx, mvy,
    output logic                          vld_out,
    output logic                          hit,
    output logic [SIDE_W-1:0]             side,
    output logic [COORD_BITS:0]           num,
    output logic [MOVE_W:0]               den
);
    import sae_pkg::*;

    localparam int GW = COORD_BITS + 1;
    localparam int DW = MOVE_W + 1;
    localparam int PW = GW + DW + 1;
    localparam int OW = GW + MOVE_FRAC_BITS + 1;

    typedef struct packed {
        logic                 zero;
        logic signed [GW-1:0] g_in;
        logic signed [GW:0]   n_in;
        logic signed [GW:0]   n_out;
        logic [DW-1:0]        d;
    } axis_t;

    function automatic axis_t axis_calc(
        input logic signed [COORD_BITS-1:0] lo, hi, olo, ohi,
        input logic signed [MOVE_W-1:0] mv);
        axis_t a;
        logic signed [GW-1:0] gi, go;
        begin
            if (mv > 0)
            begin
                gi = GW'(olo) - GW'(hi);
                go = GW'(ohi) - GW'(lo);
            end
            else
            begin
                gi = GW'(ohi) - GW'(lo);
                go = GW'(olo) - GW'(hi);
            end
            a.zero  = (mv == '0);
            a.g_in  = gi;
            a.n_in  = (mv > 0) ? (GW+1)'(gi) : -(GW+1)'(gi);
            a.n_out = (mv > 0) ? (GW+1)'(go) : -(GW+1)'(go);
            a.d     = (mv > 0) ? DW'(mv) : -DW'(mv);
            axis_calc = a;
        end
    endfunction

    axis_t ax_c, ay_c, ax_reg, ay_reg;
    logic  v1_reg, v2_reg;
    logic signed [PW-1:0] xin_yden, yin_xden, xin_yout, yin_xout, xout_yin, yout_xin;
    logic  c_xy_reg, c_ixoy_reg, c_iyox_reg;

    assign ax_c = axis_calc(ml, mr, ol, orr, mvx);
    assign ay_c = axis_calc(mt, mb, ot, ob, mvy);

    // stage one: gaps per axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= ax_c;
            ay_reg <= ay_c;
        end
    end

    // cross products of the finite times
    assign xin_yden = PW'(ax_reg.n_in)  * $signed({1'b0, ay_reg.d});
    assign yin_xden = PW'(ay_reg.n_in)  * $signed({1'b0, ax_reg.d});
    assign xin_yout = PW'(ax_reg.n_in)  * $signed({1'b0, ay_reg.d});
    assign yin_xout = PW'(ay_reg.n_out) * $signed({1'b0, ax_reg.d});
    assign xout_yin = PW'(ax_reg.n_out) * $signed({1'b0, ay_reg.d});
    assign yout_xin = PW'(ay_reg.n_in)  * $signed({1'b0, ax_reg.d});

    axis_t ax2_reg, ay2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_xy_reg   <= xin_yden > yin_xden;
            c_ixoy_reg <= xin_yout > yin_xout;
            c_iyox_reg <= yout_xin > xout_yin;
            ax2_reg    <= ax_reg;
            ay2_reg    <= ay_reg;
        end
    end

    // last stage: decision
    logic x_later, miss, hit_c;
    logic signed [OW-1:0] xi_sc, yi_sc;
    logic x_gt1, y_gt1;

    always_comb
    begin
        xi_sc = OW'(ax2_reg.n_in) <<< MOVE_FRAC_BITS;
        yi_sc = OW'(ay2_reg.n_in) <<< MOVE_FRAC_BITS;
        x_gt1 = !ax2_reg.zero && (xi_sc > $signed(OW'({1'b0, ax2_reg.d})));
        y_gt1 = !ay2_reg.zero && (yi_sc > $signed(OW'({1'b0, ay2_reg.d})));
        if (ax2_reg.zero)
            x_later = 1'b0;
        else if (ay2_reg.zero)
            x_later = 1'b1;
        else
            x_later = c_xy_reg;
        // entry versus exit; infinite exit never loses
        miss = 1'b0;
        if (ax2_reg.zero && ay2_reg.zero)
            miss = 1'b1;
        else if (ax2_reg.zero)
            miss = (ay2_reg.n_in > ay2_reg.n_out);
        else if (ay2_reg.zero)
            miss = (ax2_reg.n_in > ax2_reg.n_out);
        else
        begin
            if (ax2_reg.n_in > ax2_reg.n_out)
                miss = 1'b1;
            if (ay2_reg.n_in > ay2_reg.n_out)
                miss = 1'b1;
            if (c_ixoy_reg || c_iyox_reg)
                miss = 1'b1;
        end
        if ((ax2_reg.zero || ax2_reg.n_in < 0) && (ay2_reg.zero || ay2_reg.n_in < 0))
            miss = 1'b1;
        if (x_gt1 || y_gt1)
            miss = 1'b1;
        hit_c = !miss;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit  <= hit_c;
            side <= !hit_c ? SIDE_NONE :
                    x_later ? ((ax2_reg.g_in > 0) ? SIDE_RIGHT : SIDE_LEFT) :
                              ((ay2_reg.g_in > 0) ? SIDE_TOP : SIDE_BOTTOM);
            num  <= x_later ? ax2_reg.n_in[COORD_BITS:0] : ay2_reg.n_in[COORD_BITS:0];
            den  <= x_later ? ax2_reg.d : ay2_reg.d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out <= 1'b0;
        else if (en)
            vld_out <= v2_reg;
    end

endmodule

// ===== src/swept_aabb_entry_time.sv =====
// ----------------------------------------------------------------------------
// swept_aabb_entry_time: swept box-versus-box contact time and face
// exact compares up front, then a chain of divide cells for the time
// ----------------------------------------------------------------------------
// channel | direction | handshake      | payload
// in      | input     | in_valid/stall | in_beat_t (two boxes and move)
// out     | output    | out_valid/stall| out_beat_t (hit, time, face)
//
// one beat per cycle unless a held out beat is stalled; each beat passes the front stages,
// then the divide chain with one quotient bit per cell.
// reset clears all valid bits; the pipeline is empty after reset.
// a stall on a valid out beat freezes the whole chain and raises the stall on in.
module swept_aabb_entry_time #(
    parameter int MOVE_FRAC_BITS = sae_pkg::MOVE_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sae_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sae_pkg::out_beat_t out_data
);
    import sae_pkg::*;

    localparam int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF;
    localparam int CB    = COORD_BITS_DEF;
    localparam int NSTEP = MOVE_FRAC_BITS + TIME_FRAC_BITS + CB + 1;
    localparam int REM_W = MOVE_W + 2;

    logic en;
    logic f_vld, f_hit;
    logic [SIDE_W-1:0] f_side;
    logic [CB:0] f_num;
    logic [MOVE_W:0] f_den;

    // whole chain advances unless the held output is stalled
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    sae_front #(
        .COORD_BITS(CB), .MOVE_FRAC_BITS(MOVE_FRAC_BITS),
        .MOVE_W(MOVE_W), .SIDE_W(SIDE_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_valid),
        .ml(in_data.my_left), .mt(in_data.my_top),
        .mr(in_data.my_right), .mb(in_data.my_bottom),
        .ol(in_data.other_left), .ot(in_data.other_top),
        .orr(in_data.other_right), .ob(in_data.other_bottom),
        .mvx(in_data.move_x), .mvy(in_data.move_y),
        .vld_out(f_vld), .hit(f_hit), .side(f_side), .num(f_num), .den(f_den)
    );

    logic              c_vld  [NSTEP+1];
    logic [REM_W-1:0]  c_rem  [NSTEP+1];
    logic [REM_W-1:0]  c_den  [NSTEP+1];
    logic [NSTEP-1:0]  c_num  [NSTEP+1];
    logic [NSTEP-1:0]  c_quo  [NSTEP+1];
    logic              c_hit  [NSTEP+1];
    logic [SIDE_W-1:0] c_side [NSTEP+1];

    // head of the divide chain: numerator scaled by both fraction widths
    assign c_vld[0]  = f_vld;
    assign c_rem[0]  = '0;
    assign c_den[0]  = REM_W'(f_den);
    assign c_num[0]  = {f_num, {(NSTEP-CB-1){1'b0}}};
    assign c_quo[0]  = '0;
    assign c_hit[0]  = f_hit;
    assign c_side[0] = f_side;

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cell
        sae_div_cell #(.REM_W(REM_W), .QUO_W(NSTEP), .SIDE_W(SIDE_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vld_in(c_vld[i]), .rem_in(c_rem[i]), .den_in(c_den[i]),
            .num_in(c_num[i]), .quo_in(c_quo[i]), .hit_in(c_hit[i]),
            .side_in(c_side[i]),
            .vld_out(c_vld[i+1]), .rem_out(c_rem[i+1]), .den_out(c_den[i+1]),
            .num_out(c_num[i+1]), .quo_out(c_quo[i+1]), .hit_out(c_hit[i+1]),
            .side_out(c_side[i+1])
        );
    end

    // output beat
    assign out_valid           = c_vld[NSTEP];
    assign out_data.hit        = c_hit[NSTEP];
    assign out_data.side_code  = c_hit[NSTEP] ? c_side[NSTEP] : SIDE_NONE;
    assign out_data.entry_time = c_hit[NSTEP] ? c_quo[NSTEP][TIME_FRAC_BITS:0]
                                 : (TIME_FRAC_BITS+1)'(1) << TIME_FRAC_BITS;

`ifndef SYNTHESIS
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input not stalled while output held");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("held beat dropped");
    a_miss_side: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |-> (out_data.side_code == SIDE_NONE))
        else $error("miss with a face");
    a_hit_side: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> (out_data.side_code != SIDE_NONE))
        else $error("hit without a face");
`endif

endmodule
